@@ rtl/kaf_pkg.sv @@
// ----------------------------------------------------------------------------
// kaf_pkg: shared types and constants of the angle Kalman filter
// Register indexes, reset values, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package kaf_pkg;

  localparam int unsigned CfgW      = 31;
  localparam int unsigned IdxW      = 2;
  localparam int unsigned DataW     = 32;
  localparam int unsigned DtW       = 21;

  localparam logic [IdxW-1:0] RegQAngle = 2'd0;
  localparam logic [IdxW-1:0] RegQBias  = 2'd1;
  localparam logic [IdxW-1:0] RegRMeas  = 2'd2;

  localparam logic [CfgW-1:0] QAngleRst = 31'd66;
  localparam logic [CfgW-1:0] QBiasRst  = 31'd197;
  localparam logic [CfgW-1:0] RMeasRst  = 31'd1966;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,    // rate = gyro - bias
    ST_M_DR,    // prod = dt * rate
    ST_ANG,     // angle += prod
    ST_M_DP3,   // prod = dt * P3
    ST_INNER,   // t1 = prod - P1 - P2 + qa ; P1 -= prod, P2 -= prod
    ST_M_DIN,   // prod = dt * inner
    ST_P0P,     // P0 += prod
    ST_P12P,    // no register update; P1 and P2 change in ST_INNER
    ST_M_QB,    // prod = qb * dt
    ST_P3P,     // P3 += prod
    ST_S,       // s = P0 + r
    ST_DIV0,    // k0 = P0 / s
    ST_DIV1,    // k1 = P2 / s
    ST_Y,       // y = meas - angle
    ST_M_K0Y,
    ST_ANG2,
    ST_M_K1Y,
    ST_BIAS,
    ST_M_K0P0,
    ST_P0U,
    ST_M_K0P1,
    ST_P1U,
    ST_M_K1P0,
    ST_P2U,
    ST_M_K1P1,
    ST_P3U,
    ST_OUT
  } kaf_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

@@ rtl/kaf_stream_if.sv @@
// ----------------------------------------------------------------------------
// kaf_stream_if: valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface kaf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/kaf_divider.sv @@
// ----------------------------------------------------------------------------
// kaf_divider: restoring divider, one quotient bit per cycle
// Computes sat32((num << 16) / den), truncated toward zero; zero if den is 0.
// ----------------------------------------------------------------------------
module kaf_divider import kaf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DataW-1:0]  num_i,
  input  logic signed [DataW-1:0]  den_i,
  output logic                     done_o,
  output logic signed [DataW-1:0]  quo_o
);
  localparam int unsigned NW = 48;

  logic [NW-1:0]   rem_q, rem_d, quo_q, quo_d;
  logic [DataW-1:0] den_q, den_d;
  logic            neg_q, neg_d, zero_q, zero_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [NW-1:0]   shifted;
  logic [NW-1:0]   quo_last;
  logic [NW:0]     quo_s;
  logic [NW-1:0]   num_abs;

  always_comb begin
    num_abs = num_i[DataW-1] ? {16'd0, 32'(-num_i)} << 16 : {16'd0, num_i} << 16;
    if (num_i == 32'sh8000_0000) num_abs = 48'h8000_0000_0000;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    shifted = {rem_q[NW-2:0], quo_q[NW-1]};
    // quotient after this step, independent of a new start in the same cycle
    quo_last = {quo_q[NW-2:0], (shifted >= {16'd0, den_q})};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_abs;
      den_d  = den_i[DataW-1] ? 32'(-den_i) : den_i;
      neg_d  = num_i[DataW-1] ^ den_i[DataW-1];
      zero_d = (den_i == '0);
      cnt_d  = 6'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when it fits
      if (shifted >= {16'd0, den_q}) begin
        rem_d = shifted - {16'd0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quo_s  = neg_q ? -{1'b0, quo_last} : {1'b0, quo_last};
  assign quo_o  = zero_q ? '0 : sat32({{17{quo_s[NW]}}, quo_s});
endmodule

@@ rtl/kalman_angle_filter.sv @@
// ----------------------------------------------------------------------------
// kalman_angle_filter: two-state angle / gyro bias Kalman filter
// ----------------------------------------------------------------------------
// Channels: in_if carries one item (action, measured_angle, gyro_rate,
// time_step); out_if returns one beat per item (filtered_angle,
// unbiased_rate); cfg_if writes q_angle (0), q_gyro_bias (1), r_measure (2);
// other indexes are dropped. Angles, rates and P are signed Q16.16, noise
// values unsigned Q15.16 and time_step unsigned Q5.16. One 33x33 signed
// multiplier, a 32-bit add/sub with saturation and one bit-serial divider
// are shared under a sequencer. An update item runs ST_RATE to ST_OUT,
// waiting on the divider in ST_DIV0 and ST_DIV1; a set-angle item goes
// straight to ST_OUT. in_if.ready is high only when the sequencer is idle
// and the output register is empty, so one item is in flight at a time.
// Reset clears the state estimates, the covariance and loads the default
// noise values. When the receiver stalls, the result holds in the output
// register and no new item is taken until it is delivered.
// ----------------------------------------------------------------------------
module kalman_angle_filter import kaf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  kaf_stream_if.sink   in_if,
  kaf_stream_if.source out_if,
  kaf_stream_if.sink   cfg_if
);
  kaf_state_e state_q, state_d;

  logic [CfgW-1:0] qa_q, qb_q, rm_q;
  logic signed [DataW-1:0] ang_q, bias_q, rate_q;
  logic signed [DataW-1:0] p_q [4];
  logic signed [DataW-1:0] meas_q, gyro_q, t1_q, s_q, k0_q, k1_q, y_q;
  logic signed [DataW-1:0] p0o_q, p1o_q;
  logic signed [DataW-1:0] prod_q;
  logic [DtW-1:0] dt_q;
  logic out_v_q;
  logic signed [DataW-1:0] out_ang_q, out_rate_q;

  // shared multiplier operands
  logic signed [DataW:0] ma, mb;
  logic signed [65:0]    mp;
  // shared adder
  logic signed [DataW-1:0] aa, ab;
  logic                    asub;
  logic signed [65:0]      asum;
  logic signed [DataW-1:0] ares;

  logic div_start, div_done;
  logic signed [DataW-1:0] div_num, div_quo;

  logic in_acc;
  assign in_if.ready = (state_q == ST_IDLE) && !out_v_q;
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = in_if.data.action ? ST_OUT : ST_RATE;
      ST_DIV0,
      ST_DIV1:   if (div_done) state_d = kaf_state_e'(state_q + 5'd1);
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = kaf_state_e'(state_q + 5'd1);
    endcase
  end

  always_comb begin
    ma = '0; mb = '0;
    case (state_q)
      ST_M_DR:   begin ma = {1'b0, 11'd0, dt_q}; mb = 33'(rate_q); end
      ST_M_DP3:  begin ma = {1'b0, 11'd0, dt_q}; mb = 33'(p_q[3]); end
      ST_M_DIN:  begin ma = {1'b0, 11'd0, dt_q}; mb = 33'(t1_q); end
      ST_M_QB:   begin ma = {2'b0, qb_q}; mb = {1'b0, 11'd0, dt_q}; end
      ST_M_K0Y:  begin ma = 33'(k0_q); mb = 33'(y_q); end
      ST_M_K1Y:  begin ma = 33'(k1_q); mb = 33'(y_q); end
      ST_M_K0P0: begin ma = 33'(k0_q); mb = 33'(p_q[0]); end
      ST_M_K0P1: begin ma = 33'(k0_q); mb = 33'(p_q[1]); end
      ST_M_K1P0: begin ma = 33'(k1_q); mb = 33'(p0o_q); end
      ST_M_K1P1: begin ma = 33'(k1_q); mb = 33'(p1o_q); end
      default:   begin ma = '0; mb = '0; end
    endcase
    mp = ma * mb;
  end

  always_comb begin
    aa = '0; ab = '0; asub = 1'b0;
    case (state_q)
      ST_RATE:  begin aa = gyro_q; ab = bias_q; asub = 1'b1; end
      ST_ANG,
      ST_ANG2:  begin aa = ang_q; ab = prod_q; end
      ST_P0P:   begin aa = p_q[0]; ab = prod_q; end
      ST_P3P:   begin aa = p_q[3]; ab = prod_q; end
      ST_Y:     begin aa = meas_q; ab = ang_q; asub = 1'b1; end
      ST_BIAS:  begin aa = bias_q; ab = prod_q; end
      ST_P0U:   begin aa = p_q[0]; ab = prod_q; asub = 1'b1; end
      ST_P1U:   begin aa = p_q[1]; ab = prod_q; asub = 1'b1; end
      ST_P2U:   begin aa = p_q[2]; ab = prod_q; asub = 1'b1; end
      ST_P3U:   begin aa = p_q[3]; ab = prod_q; asub = 1'b1; end
      default:  begin aa = '0; ab = '0; end
    endcase
    asum = asub ? 66'(aa) - 66'(ab) : 66'(aa) + 66'(ab);
    ares = sat32(asum);
  end

  assign div_start = ((state_q == ST_S) || (state_q == ST_DIV0 && div_done));
  assign div_num   = (state_q == ST_S) ? p_q[0] : p_q[2];

  kaf_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ((state_q == ST_S) ? sat32(66'(p_q[0]) + 66'(rm_q)) : s_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      qa_q <= QAngleRst; qb_q <= QBiasRst; rm_q <= RMeasRst;
      ang_q <= '0; bias_q <= '0; rate_q <= '0;
      for (int i = 0; i < 4; i++) p_q[i] <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_if.valid) begin
        case (cfg_if.data.index)
          RegQAngle: qa_q <= cfg_if.data.value[CfgW-1:0];
          RegQBias:  qb_q <= cfg_if.data.value[CfgW-1:0];
          RegRMeas:  rm_q <= cfg_if.data.value[CfgW-1:0];
          default:   ;
        endcase
      end
      if (in_acc && in_if.data.action) ang_q <= in_if.data.measured_angle;
      case (state_q)
        ST_RATE:  rate_q <= ares;
        ST_ANG,
        ST_ANG2:  ang_q  <= ares;
        ST_INNER: begin
          p_q[1] <= sat32(66'(p_q[1]) - 66'(prod_q));
          p_q[2] <= sat32(66'(p_q[2]) - 66'(prod_q));
        end
        ST_P0P,
        ST_P0U:   p_q[0] <= ares;
        ST_P3P,
        ST_P3U:   p_q[3] <= ares;
        ST_BIAS:  bias_q <= ares;
        ST_P1U:   p_q[1] <= ares;
        ST_P2U:   p_q[2] <= ares;
        default:  ;
      endcase
      if (state_q == ST_OUT) out_v_q <= 1'b1;
      else if (out_if.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q <= in_if.data.measured_angle;
      gyro_q <= in_if.data.gyro_rate;
      dt_q   <= in_if.data.time_step;
    end
    // product >> 16 floors on the arithmetic shift
    prod_q <= sat32(mp >>> 16);
    if (state_q == ST_INNER)
      t1_q <= sat32(66'(prod_q) - 66'(p_q[1]) - 66'(p_q[2]) + 66'(qa_q));
    if (state_q == ST_S) s_q <= sat32(66'(p_q[0]) + 66'(rm_q));
    if (state_q == ST_DIV0 && div_done) k0_q <= div_quo;
    if (state_q == ST_DIV1 && div_done) k1_q <= div_quo;
    if (state_q == ST_Y) y_q <= ares;
    // hold P0 and P1 from before the covariance update for the k1 products
    if (state_q == ST_M_K0P0) begin
      p0o_q <= p_q[0];
      p1o_q <= p_q[1];
    end
    if (state_q == ST_OUT) begin
      out_ang_q  <= ang_q;
      out_rate_q <= rate_q;
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.data.filtered_angle = out_ang_q;
  assign out_if.data.unbiased_rate  = out_rate_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_acc) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_if.ready) |=> (out_v_q && $stable(out_ang_q)))
    else $error("result dropped under stall");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |=> out_v_q) else $error("result not raised");
endmodule
